@@ rtl/sor_pkg.sv @@
// ----------------------------------------------------------------------------
// sor_pkg
// Shared types, codes and helper functions of the orbit representative core.
// ----------------------------------------------------------------------------
`default_nettype none

package sor_pkg;

    // default sizes of the mask store
    localparam int MAX_GROUP_DEF  = 256;
    localparam int MAX_STAGES_DEF = 11;

    // depth of the queue between front and back
    localparam int QDEPTH = 2;

    // item opcodes
    localparam logic [1:0] OP_LOAD_MASK  = 2'd0;
    localparam logic [1:0] OP_LOAD_SHIFT = 2'd1;
    localparam logic [1:0] OP_CLASSIFY   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_BITS_IN_USE = 2'd0;
    localparam logic [1:0] REG_SPIN_INV    = 2'd1;
    localparam logic [1:0] REG_GROUP_COUNT = 2'd2;
    localparam logic [1:0] REG_STAGE_COUNT = 2'd3;

    // reset values of the configuration registers
    localparam logic [6:0] BITS_IN_USE_RST = 7'd64;
    localparam logic [8:0] GROUP_COUNT_RST = 9'd1;

    // queued command from front to back
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  gidx;
        logic [3:0]  sidx;
        logic [63:0] data;
    } sor_cmd_t;

    // configuration seen by the back end
    typedef struct packed {
        logic [6:0] bits_in_use;
        logic       spin_inversion_on;
        logic [8:0] group_count;
        logic [3:0] stage_count;
    } sor_cfg_t;

    // one delta-swap stage
    function automatic logic [63:0] sor_swap(input logic [63:0] v, input logic [63:0] m,
                                             input logic [5:0] d);
        logic [63:0] t;
        t = ((v >> d) ^ v) & m;
        return (v ^ t) ^ (t << d);
    endfunction

    // inversion mask with the low bits set
    function automatic logic [63:0] sor_inv_mask(input logic [6:0] bits);
        logic [63:0] m;
        if (bits >= 7'd64) begin
            m = '1;
        end
        else begin
            m = (64'd1 << bits[5:0]) - 64'd1;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

@@ rtl/sor_fifo.sv @@
// ----------------------------------------------------------------------------
// sor_fifo
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sor_fifo
    import sor_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     wr,
    input  wire sor_cmd_t wdata,
    output logic          full,
    input  wire logic     rd,
    output sor_cmd_t      rdata,
    output logic          valid
);

    localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    sor_cmd_t         store_reg [QDEPTH];
    logic [QAW-1:0]   wp_reg, wp_next;
    logic [QAW-1:0]   rp_reg, rp_next;
    logic [QAW:0]     cnt_reg, cnt_next;

    assign full  = (32'(cnt_reg) == QDEPTH);
    assign valid = (cnt_reg != '0);
    assign rdata = store_reg[rp_reg];

    // pointer and count update
    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (wr)
        begin
            wp_next = (32'(wp_reg) == QDEPTH - 1) ? '0 : wp_reg + 1'b1;
        end
        if (rd)
        begin
            rp_next = (32'(rp_reg) == QDEPTH - 1) ? '0 : rp_reg + 1'b1;
        end
        if (wr && !rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            store_reg[wp_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

@@ rtl/sor_front.sv @@
// ----------------------------------------------------------------------------
// sor_front
// Accepts items, drops those that do nothing, and queues the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module sor_front
    import sor_pkg::*;
#(
    parameter int MAX_GROUP  = MAX_GROUP_DEF,
    parameter int MAX_STAGES = MAX_STAGES_DEF
)
(
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  opcode,
    input  wire logic [7:0]  group_index,
    input  wire logic [3:0]  stage_index,
    input  wire logic [63:0] mask_word,
    input  wire logic [5:0]  shift_amount,
    input  wire logic [63:0] basis_state,
    input  wire logic        q_full,
    output logic             q_push,
    output sor_cmd_t         q_cmd
);

    logic keep;
    logic g_ok;
    logic s_ok;

    assign full = q_full;
    assign g_ok = (32'(group_index) < MAX_GROUP);
    assign s_ok = (32'(stage_index) < MAX_STAGES);

    // classify the item and build the queued command
    always_comb
    begin
        q_cmd.op   = opcode;
        q_cmd.gidx = group_index;
        q_cmd.sidx = stage_index;
        q_cmd.data = basis_state;
        keep       = 1'b0;
        case (opcode)
            OP_LOAD_MASK:
            begin
                keep       = g_ok && s_ok;
                q_cmd.data = mask_word;
            end
            OP_LOAD_SHIFT:
            begin
                keep       = s_ok;
                q_cmd.data = 64'(shift_amount);
            end
            OP_CLASSIFY:
            begin
                keep = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign q_push = push && !q_full && keep;

endmodule

`default_nettype wire

@@ rtl/sor_back.sv @@
// ----------------------------------------------------------------------------
// sor_back
// Runs queued commands: table loads and the pipelined orbit minimum search.
// ----------------------------------------------------------------------------
`default_nettype none

module sor_back
    import sor_pkg::*;
#(
    parameter int MAX_GROUP  = MAX_GROUP_DEF,
    parameter int MAX_STAGES = MAX_STAGES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  wire sor_cmd_t    q_cmd,
    output logic             q_pop,
    input  wire sor_cfg_t    cfg,
    output logic             empty,
    input  wire logic        pop,
    output logic [63:0]      representative,
    output logic [8:0]       symmetry_index
);

    localparam int GW = $clog2(MAX_GROUP);
    localparam int CW = $clog2(MAX_GROUP + 1);
    localparam int NL = MAX_STAGES;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [GW-1:0] g_cnt_reg, g_cnt_next;
    logic [63:0]   x_reg, x_next;

    logic [31:0]   gc_wide;
    logic [CW-1:0] groups;
    logic          last_g;
    logic          issue;
    logic          mask_we;
    logic          shift_we;
    logic          start;
    logic          busy;
    logic [63:0]   inv;

    // stage pipeline
    logic          lv_valid_reg [NL+1];
    logic [GW-1:0] lv_g_reg     [NL+1];
    logic [63:0]   lv_v_reg     [NL+1];
    logic          lv_valid_next [NL+1];
    logic [GW-1:0] lv_g_next     [NL+1];
    logic [63:0]   lv_v_next     [NL+1];
    logic [63:0]   mask_rd      [NL];
    logic [5:0]    shift_reg    [NL];

    // inversion pick level
    logic          pk_valid_reg, pk_valid_next;
    logic [63:0]   pk_v_reg, pk_v_next;
    logic [8:0]    pk_idx_reg, pk_idx_next;

    // running minimum
    logic          best_ok_reg, best_ok_next;
    logic [63:0]   best_v_reg, best_v_next;
    logic [8:0]    best_idx_reg, best_idx_next;

    // result register
    logic          out_full_reg, out_full_next;
    logic [63:0]   out_v_reg, out_v_next;
    logic [8:0]    out_idx_reg, out_idx_next;
    logic          out_load;

    // effective group count
    always_comb
    begin
        gc_wide = 32'(cfg.group_count);
        if (gc_wide == 32'd0)
        begin
            groups = CW'(1);
        end
        else if (gc_wide > 32'(MAX_GROUP))
        begin
            groups = CW'(MAX_GROUP);
        end
        else
        begin
            groups = CW'(gc_wide);
        end
    end

    assign inv    = sor_inv_mask(cfg.bits_in_use);
    assign last_g = ((32'(g_cnt_reg) + 32'd1) == 32'(groups));

    // command dispatch and sequencing
    always_comb
    begin
        state_next = state_reg;
        g_cnt_next = g_cnt_reg;
        x_next     = x_reg;
        q_pop      = 1'b0;
        mask_we    = 1'b0;
        shift_we   = 1'b0;
        start      = 1'b0;
        issue      = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_cmd.op)
                        OP_LOAD_MASK:  mask_we  = 1'b1;
                        OP_LOAD_SHIFT: shift_we = 1'b1;
                        OP_CLASSIFY:
                        begin
                            start      = 1'b1;
                            x_next     = q_cmd.data;
                            g_cnt_next = '0;
                            state_next = ST_RUN;
                        end
                        default: q_pop = 1'b1;
                    endcase
                end
            end
            ST_RUN:
            begin
                issue      = 1'b1;
                g_cnt_next = g_cnt_reg + 1'b1;
                if (last_g)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_full_reg || pop)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // mask memories, one per stage, and shift registers
    for (genvar s = 0; s < NL; s++)
    begin : g_stage
        logic [63:0]   mem [MAX_GROUP];
        logic [GW-1:0] rd_addr;

        if (s == 0)
        begin : g_first
            assign rd_addr = g_cnt_reg;
        end
        else
        begin : g_rest
            assign rd_addr = lv_g_reg[s-1];
        end

        always_ff @(posedge clk)
        begin
            if (mask_we && (32'(q_cmd.sidx) == s))
            begin
                mem[GW'(q_cmd.gidx)] <= q_cmd.data;
            end
            mask_rd[s] <= mem[rd_addr];
        end

        always_ff @(posedge clk)
        begin
            if (shift_we && (32'(q_cmd.sidx) == s))
            begin
                shift_reg[s] <= q_cmd.data[5:0];
            end
        end
    end

    // pipeline level update
    always_comb
    begin
        lv_valid_next[0] = issue;
        lv_g_next[0]     = g_cnt_reg;
        lv_v_next[0]     = x_reg;
        for (int s = 0; s < NL; s++)
        begin
            lv_valid_next[s+1] = lv_valid_reg[s];
            lv_g_next[s+1]     = lv_g_reg[s];
            if ((32'(cfg.stage_count) > s) && (lv_g_reg[s] != '0))
            begin
                lv_v_next[s+1] = sor_swap(lv_v_reg[s], mask_rd[s], shift_reg[s]);
            end
            else
            begin
                lv_v_next[s+1] = lv_v_reg[s];
            end
        end
    end

    // pipeline busy flag
    always_comb
    begin
        busy = pk_valid_reg;
        for (int s = 0; s <= NL; s++)
        begin
            busy = busy | lv_valid_reg[s];
        end
    end

    // choose between the image and its inversion
    always_comb
    begin
        pk_valid_next = lv_valid_reg[NL];
        pk_v_next     = lv_v_reg[NL];
        pk_idx_next   = 9'(lv_g_reg[NL]);
        if (cfg.spin_inversion_on && ((lv_v_reg[NL] ^ inv) < lv_v_reg[NL]))
        begin
            pk_v_next   = lv_v_reg[NL] ^ inv;
            pk_idx_next = 9'(32'(groups) + 32'(lv_g_reg[NL]));
        end
    end

    // running minimum
    always_comb
    begin
        best_ok_next  = best_ok_reg;
        best_v_next   = best_v_reg;
        best_idx_next = best_idx_reg;
        if (start)
        begin
            best_ok_next = 1'b0;
        end
        else if (pk_valid_reg && (!best_ok_reg || (pk_v_reg < best_v_reg)))
        begin
            best_ok_next  = 1'b1;
            best_v_next   = pk_v_reg;
            best_idx_next = pk_idx_reg;
        end
    end

    // result register
    always_comb
    begin
        out_full_next = out_full_reg;
        out_v_next    = out_v_reg;
        out_idx_next  = out_idx_reg;
        if (out_load)
        begin
            out_full_next = 1'b1;
            out_v_next    = best_v_reg;
            out_idx_next  = best_idx_reg;
        end
        else if (pop)
        begin
            out_full_next = 1'b0;
        end
    end

    assign empty          = !out_full_reg;
    assign representative = out_v_reg;
    assign symmetry_index = out_idx_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pk_valid_reg <= 1'b0;
            best_ok_reg  <= 1'b0;
            out_full_reg <= 1'b0;
            for (int s = 0; s <= NL; s++)
            begin
                lv_valid_reg[s] <= 1'b0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            pk_valid_reg <= pk_valid_next;
            best_ok_reg  <= best_ok_next;
            out_full_reg <= out_full_next;
            for (int s = 0; s <= NL; s++)
            begin
                lv_valid_reg[s] <= lv_valid_next[s];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        g_cnt_reg    <= g_cnt_next;
        x_reg        <= x_next;
        pk_v_reg     <= pk_v_next;
        pk_idx_reg   <= pk_idx_next;
        best_v_reg   <= best_v_next;
        best_idx_reg <= best_idx_next;
        out_v_reg    <= out_v_next;
        out_idx_reg  <= out_idx_next;
        for (int s = 0; s <= NL; s++)
        begin
            lv_g_reg[s] <= lv_g_next[s];
            lv_v_reg[s] <= lv_v_next[s];
        end
    end

endmodule

`default_nettype wire

@@ rtl/symmetry_orbit_representative_core.sv @@
// ----------------------------------------------------------------------------
// symmetry_orbit_representative_core
// Smallest state in the orbit of a 64-bit basis state under a bit-permutation
// group, with optional spin inversion.
// ----------------------------------------------------------------------------
// A classify item occupies the back end until its result is loaded:
// one group element enters the delta-swap pipeline per cycle, then the
// pipeline drains through the pick and minimum stages.
// Loads write the tables; bad opcodes and out-of-range loads are dropped.
// A two-entry command queue and a result register decouple the ports.
// Reset clears control state and sets the configuration registers to their
// defaults; the mask and shift tables hold nothing until written.
`default_nettype none

module symmetry_orbit_representative_core
    import sor_pkg::*;
#(
    parameter int MAX_GROUP  = MAX_GROUP_DEF,
    parameter int MAX_STAGES = MAX_STAGES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // item input
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  opcode,
    input  wire logic [7:0]  group_index,
    input  wire logic [3:0]  stage_index,
    input  wire logic [63:0] mask_word,
    input  wire logic [5:0]  shift_amount,
    input  wire logic [63:0] basis_state,
    // result output
    output logic             empty,
    input  wire logic        pop,
    output logic [63:0]      representative,
    output logic [8:0]       symmetry_index,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    sor_cmd_t  f_cmd;
    sor_cmd_t  q_cmd;
    logic      f_push;
    logic      q_full;
    logic      q_valid;
    logic      q_pop;
    sor_cfg_t  cfg_reg, cfg_next;
    logic      cfg_wr;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_BITS_IN_USE: cfg_next.bits_in_use       = pwdata[6:0];
                REG_SPIN_INV:    cfg_next.spin_inversion_on = pwdata[0];
                REG_GROUP_COUNT: cfg_next.group_count       = pwdata[8:0];
                REG_STAGE_COUNT: cfg_next.stage_count       = pwdata[3:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bits_in_use       <= BITS_IN_USE_RST;
            cfg_reg.spin_inversion_on <= 1'b0;
            cfg_reg.group_count       <= GROUP_COUNT_RST;
            cfg_reg.stage_count       <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // register read back
    always_comb
    begin
        case (paddr[3:2])
            REG_BITS_IN_USE: prdata = 32'(cfg_reg.bits_in_use);
            REG_SPIN_INV:    prdata = 32'(cfg_reg.spin_inversion_on);
            REG_GROUP_COUNT: prdata = 32'(cfg_reg.group_count);
            REG_STAGE_COUNT: prdata = 32'(cfg_reg.stage_count);
            default:         prdata = '0;
        endcase
    end

    // front end
    sor_front #(
        .MAX_GROUP  (MAX_GROUP),
        .MAX_STAGES (MAX_STAGES)
    ) u_front (
        .push         (push),
        .full         (full),
        .opcode       (opcode),
        .group_index  (group_index),
        .stage_index  (stage_index),
        .mask_word    (mask_word),
        .shift_amount (shift_amount),
        .basis_state  (basis_state),
        .q_full       (q_full),
        .q_push       (f_push),
        .q_cmd        (f_cmd)
    );

    // command queue
    sor_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (f_push),
        .wdata (f_cmd),
        .full  (q_full),
        .rd    (q_pop),
        .rdata (q_cmd),
        .valid (q_valid)
    );

    // back end
    sor_back #(
        .MAX_GROUP  (MAX_GROUP),
        .MAX_STAGES (MAX_STAGES)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_cmd          (q_cmd),
        .q_pop          (q_pop),
        .cfg            (cfg_reg),
        .empty          (empty),
        .pop            (pop),
        .representative (representative),
        .symmetry_index (symmetry_index)
    );

endmodule

`default_nettype wire
